// ===== sv/fcr_pkg.sv =====
// Shared constants, codes and types for the floppy controller register front end.
package fcr_pkg;

	// Drive geometry
	localparam int TRACKS            = 77;
	localparam int SECTORS_PER_TRACK = 26;

	// Field widths
	localparam int OPC_W  = 3;
	localparam int BYTE_W = 8;
	localparam int SEC_W  = 5;
	localparam int LSEC_W = 11;
	localparam int CNT_W  = 5;
	localparam int ADDR_W = 16;
	localparam int KIND_W = 2;
	localparam int XOP_W  = 3;

	// Bus opcodes
	localparam logic [OPC_W-1:0] OPC_RD_STATUS = 3'd0;
	localparam logic [OPC_W-1:0] OPC_RD_KIND   = 3'd1;
	localparam logic [OPC_W-1:0] OPC_RD_RESULT = 3'd2;
	localparam logic [OPC_W-1:0] OPC_WR_ADDR_L = 3'd3;
	localparam logic [OPC_W-1:0] OPC_WR_ADDR_H = 3'd4;
	localparam logic [OPC_W-1:0] OPC_RESET     = 3'd5;
	localparam logic [OPC_W-1:0] OPC_DRV_STAT  = 3'd6;
	localparam logic [OPC_W-1:0] OPC_NONE      = 3'd7;

	// Instruction operations (instruction byte bits 2:0)
	localparam logic [2:0] INS_NOP     = 3'd0;
	localparam logic [2:0] INS_SEEK    = 3'd1;
	localparam logic [2:0] INS_FORMAT  = 3'd2;
	localparam logic [2:0] INS_RECAL   = 3'd3;
	localparam logic [2:0] INS_READ    = 3'd4;
	localparam logic [2:0] INS_VERIFY  = 3'd5;
	localparam logic [2:0] INS_WRITE   = 3'd6;
	localparam logic [2:0] INS_WR_DEL  = 3'd7;

	// Transfer operations
	localparam logic [XOP_W-1:0] XOP_READ   = 3'd0;
	localparam logic [XOP_W-1:0] XOP_FORMAT = 3'd4;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_IOERR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READY = 2'd2;

	// Error bits
	localparam logic [BYTE_W-1:0] ERR_NONE  = 8'h00;
	localparam logic [BYTE_W-1:0] ERR_NRDY  = 8'h80;
	localparam logic [BYTE_W-1:0] ERR_WPROT = 8'h20;
	localparam logic [BYTE_W-1:0] ERR_ADDR  = 8'h08;

	// Ready bits in the result byte
	localparam logic [BYTE_W-1:0] RES_RDY0 = 8'h40;
	localparam logic [BYTE_W-1:0] RES_RDY1 = 8'h80;

	// Outcome of one command check
	typedef struct packed {
		logic [BYTE_W-1:0] err;
		logic              xv;
		logic [XOP_W-1:0]  xop;
		logic              xunit;
		logic [LSEC_W-1:0] xsec;
		logic [CNT_W-1:0]  xcnt;
	} cmd_result_t;

endpackage

// ===== sv/fcr_cmd_check.sv =====
// Command decode: drive ready, range and write protect checks, transfer request.
module fcr_cmd_check import fcr_pkg::*; (
	input  logic [BYTE_W-1:0] instr_byte,
	input  logic [BYTE_W-1:0] sector_count,
	input  logic [BYTE_W-1:0] track_addr,
	input  logic [SEC_W-1:0]  sector_num,
	input  logic [1:0]        ready_bits,
	input  logic [1:0]        protect_bits,
	output cmd_result_t       res
);

	localparam int PROD_W = 13; // 255 * 31 fits

	logic [2:0]        op;
	logic              unit;
	logic              unit_rdy;
	logic              unit_prot;
	logic              trk_bad;
	logic              rng_bad;
	logic [8:0]        sec_end;
	logic [PROD_W-1:0] trk_base;
	logic [PROD_W-1:0] lin_sec;

	assign op        = instr_byte[2:0];
	assign unit      = instr_byte[4];
	assign unit_rdy  = ready_bits[unit];
	assign unit_prot = protect_bits[unit];
	assign trk_bad   = track_addr >= BYTE_W'(TRACKS);
	assign sec_end   = 9'(sector_num) + 9'(sector_count);
	assign rng_bad   = trk_bad || (sector_num == '0)
		|| (sector_num > SEC_W'(SECTORS_PER_TRACK))
		|| (sector_count > BYTE_W'(SECTORS_PER_TRACK))
		|| (sec_end > 9'(SECTORS_PER_TRACK + 1));
	assign trk_base  = PROD_W'(track_addr) * PROD_W'(SECTORS_PER_TRACK);
	assign lin_sec   = trk_base + PROD_W'(sector_num) - PROD_W'(1);

	always_comb begin
		res = '0;
		if (!unit_rdy) begin
			res.err = ERR_NRDY;
		end else begin
			unique case (op) inside
				INS_SEEK: begin
					if (trk_bad) res.err = ERR_ADDR;
				end
				INS_FORMAT: begin
					if (trk_bad) begin
						res.err = ERR_ADDR;
					end else if (unit_prot) begin
						res.err = ERR_NRDY;
					end else begin
						res.xv    = 1'b1;
						res.xop   = XOP_FORMAT;
						res.xunit = unit;
						res.xsec  = trk_base[LSEC_W-1:0];
						res.xcnt  = CNT_W'(SECTORS_PER_TRACK);
					end
				end
				INS_READ, INS_VERIFY, INS_WRITE, INS_WR_DEL: begin
					if (rng_bad) begin
						res.err = ERR_ADDR;
					end else if (op[1] && unit_prot) begin
						res.err = ERR_WPROT;
					end else begin
						res.xv    = 1'b1;
						res.xop   = XOP_READ + XOP_W'(op[1:0]);
						res.xunit = unit;
						res.xsec  = lin_sec[LSEC_W-1:0];
						res.xcnt  = sector_count[CNT_W-1:0];
					end
				end
				default: begin
					res.err = ERR_NONE; // nop, recalibrate
				end
			endcase
		end
	end

endmodule

// ===== sv/floppy_controller_command_registers.sv =====
// Top level: register front end of a two-drive floppy controller.
// One bus transaction enters per cycle while the output is not stalled, and every
// transaction yields exactly one result transaction. The input register holds
// the transaction, one pass of shallow decode and check logic (one small
// constant multiply for the linear sector) updates the controller registers
// and loads the result register at the same edge, so the next transaction
// already sees the updated state. The input side keeps accepting while a
// result waits, as long as the result register is free or being drained in
// that cycle; a stalled output backs up into the input register.
// Input s_tuser carries the opcode; command parameter block fields ride in
// s_tdata. Output m_tuser flags a media transfer request whose fields sit in
// m_tdata; they are zero when no transfer is issued.
module floppy_controller_command_registers import fcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] bus_data, [15:8] chan_word, [23:16] instr_byte, [31:24] sector_count,
	// [39:32] track_addr, [47:40] sector_field, [49:48] unit_ready,
	// [51:50] unit_protect, [55:52] zero
	input  logic [55:0] s_tdata,
	// [2:0] opcode
	input  logic [2:0]  s_tuser,
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] read_data, [8] irq_pending, [11:9] xfer_op, [12] xfer_unit,
	// [23:13] xfer_sector, [28:24] xfer_count, [44:29] iopb_address, [47:45] zero
	output logic [47:0] m_tdata,
	// [0] xfer_valid
	output logic        m_tuser
);

	// Input register
	logic              valid_s1;
	logic [OPC_W-1:0]  opcode_s1;
	logic [BYTE_W-1:0] bus_data_s1;
	logic [BYTE_W-1:0] chan_word_s1;
	logic [BYTE_W-1:0] instr_byte_s1;
	logic [BYTE_W-1:0] sector_count_s1;
	logic [BYTE_W-1:0] track_addr_s1;
	logic [SEC_W-1:0]  sector_num_s1;
	logic [1:0]        unit_ready_s1;
	logic [1:0]        unit_protect_s1;

	// Controller registers
	logic [ADDR_W-1:0] block_addr_q;
	logic [1:0]        ready_q;
	logic              irq_q;
	logic              present_q;
	logic [KIND_W-1:0] kind_q;
	logic [BYTE_W-1:0] err_q;
	logic [1:0]        prot_q;

	// Next values
	logic [ADDR_W-1:0] block_addr_d;
	logic [1:0]        ready_d;
	logic              irq_d;
	logic              present_d;
	logic [KIND_W-1:0] kind_d;
	logic [BYTE_W-1:0] err_d;
	logic [1:0]        prot_d;
	logic [BYTE_W-1:0] rd_d;

	// Result register
	logic              out_valid_q;
	logic [47:0]       out_data_q;
	logic              out_xv_q;

	logic              advance;
	cmd_result_t       chk;
	cmd_result_t       xfer;

	// s1 moves on when the result register is empty or drained this cycle
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1       <= s_tuser;
			bus_data_s1     <= s_tdata[7:0];
			chan_word_s1    <= s_tdata[15:8];
			instr_byte_s1   <= s_tdata[23:16];
			sector_count_s1 <= s_tdata[31:24];
			track_addr_s1   <= s_tdata[39:32];
			sector_num_s1   <= s_tdata[44:40]; // sector number is the low five bits
			unit_ready_s1   <= s_tdata[49:48];
			unit_protect_s1 <= s_tdata[51:50];
		end
	end

	fcr_cmd_check u_check (
		.instr_byte   (instr_byte_s1),
		.sector_count (sector_count_s1),
		.track_addr   (track_addr_s1),
		.sector_num   (sector_num_s1),
		.ready_bits   (ready_q),
		.protect_bits (prot_q),
		.res          (chk)
	);

	// Register file update and read mux
	always_comb begin
		block_addr_d = block_addr_q;
		ready_d      = ready_q;
		irq_d        = irq_q;
		present_d    = present_q;
		kind_d       = kind_q;
		err_d        = err_q;
		prot_d       = prot_q;
		rd_d         = '0;
		xfer         = '0;
		unique case (opcode_s1)
			OPC_RD_STATUS: begin
				rd_d = {4'b0, present_q, irq_q, ready_q};
			end
			OPC_RD_KIND: begin
				irq_d = 1'b0;
				rd_d  = BYTE_W'(kind_q);
			end
			OPC_RD_RESULT: begin
				if (kind_q == KIND_READY) begin
					rd_d = (ready_q[0] ? RES_RDY0 : ERR_NONE) | (ready_q[1] ? RES_RDY1 : ERR_NONE);
				end else begin
					rd_d   = err_q;
					kind_d = KIND_READY;
				end
			end
			OPC_WR_ADDR_L: begin
				block_addr_d = ADDR_W'(bus_data_s1);
			end
			OPC_WR_ADDR_H: begin
				// high byte is ORed in; only the low write replaces the address
				block_addr_d = block_addr_q | {bus_data_s1, 8'h00};
				kind_d       = KIND_IOERR;
				err_d        = chk.err;
				xfer         = chk;
				if (chan_word_s1[5:4] == 2'b00) irq_d = 1'b1;
			end
			OPC_RESET: begin
				kind_d    = KIND_READY;
				err_d     = ERR_NONE;
				irq_d     = 1'b0;
				ready_d   = unit_ready_s1;
				prot_d    = unit_protect_s1;
				present_d = (unit_ready_s1 != 2'b00);
			end
			OPC_DRV_STAT: begin
				prot_d = unit_protect_s1;
				// ready change raises an interrupt unless an I/O result is pending
				if (kind_q != KIND_IOERR && unit_ready_s1 != ready_q) begin
					ready_d = unit_ready_s1;
					irq_d   = 1'b1;
				end
			end
			default: begin
				rd_d = '0; // no effect
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_addr_q <= '0;
			ready_q      <= '0;
			irq_q        <= 1'b0;
			present_q    <= 1'b0;
			kind_q       <= KIND_READY;
			err_q        <= ERR_NONE;
			prot_q       <= '0;
		end else if (advance) begin
			block_addr_q <= block_addr_d;
			ready_q      <= ready_d;
			irq_q        <= irq_d;
			present_q    <= present_d;
			kind_q       <= kind_d;
			err_q        <= err_d;
			prot_q       <= prot_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_xv_q   <= xfer.xv;
			out_data_q <= {3'b000, block_addr_d, xfer.xcnt, xfer.xsec, xfer.xunit,
				xfer.xop, irq_d, rd_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_xv_q;

	// Transfer fields are clear whenever no transfer is flagged
	a_xfer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[28:9] == '0))
		else $error("transfer fields set without a transfer request");

	// A transfer never exceeds one track and stays on the disk
	a_xfer_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> ((m_tdata[28:24] <= CNT_W'(SECTORS_PER_TRACK))
		&& (m_tdata[23:13] < LSEC_W'(TRACKS * SECTORS_PER_TRACK))
		&& (m_tdata[11:9] <= XOP_FORMAT)))
		else $error("transfer request out of range");

	// A controller reset leaves a ready result and no error
	a_reset_item: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && opcode_s1 == OPC_RESET) |=> (kind_q == KIND_READY && err_q == ERR_NONE
		&& !irq_q))
		else $error("reset transaction did not clear result state");

	// Input side only stalls while the input register is occupied and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	// Transfers are only requested by a command
	a_xfer_src: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && xfer.xv) |-> (opcode_s1 == OPC_WR_ADDR_H && err_d == ERR_NONE))
		else $error("transfer request outside a clean command");

endmodule

// ===== bench/floppy_controller_command_registers_tb.sv =====
// Testbench for the floppy controller register front end: directed and random traffic.
module floppy_controller_command_registers_tb;
	import fcr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// run sizing
	localparam int RANDOM_ITEMS  = 1550; // random traffic with idling
	localparam int STREAM_ITEMS  = 200;  // final back-to-back stretch
	localparam int DRAIN_CYCLES  = 10;   // margin after the last result drains
	localparam int STALL_LIMIT   = 1000; // cycles with no transaction on either side
	localparam int MAX_PRINTED   = 100;

	// one bus transaction as the block sees it
	typedef struct packed {
		logic [OPC_W-1:0]  opcode;
		logic [BYTE_W-1:0] bus_data, chan_word, instr_byte, sector_count, track_addr,
		                   sector_field;
		logic [1:0]        unit_ready, unit_protect;
	} bus_item_t;

	// one result transaction, unpacked
	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              irq_pending;
		logic              xfer_valid;
		logic [XOP_W-1:0]  xfer_op;
		logic              xfer_unit;
		logic [LSEC_W-1:0] xfer_sector;
		logic [CNT_W-1:0]  xfer_count;
		logic [ADDR_W-1:0] iopb_address;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;

	floppy_controller_command_registers uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// predicted controller registers, reset values
	logic [ADDR_W-1:0] ctl_addr    = '0;
	logic [1:0]        ctl_ready   = '0;
	logic              ctl_irq     = 1'b0;
	logic              ctl_present = 1'b0;
	logic [KIND_W-1:0] ctl_kind    = KIND_READY;
	logic [BYTE_W-1:0] ctl_err     = ERR_NONE;
	logic [1:0]        ctl_protect = '0;

	bus_result_t expected_results[$];

	// bookkeeping
	int mismatches     = 0;
	int sent_items     = 0;
	int checked        = 0;
	int xfers_issued   = 0;
	int cmds_rejected  = 0;
	int ready_changes  = 0;
	int idle_cycles    = 0;
	bit calm           = 1'b0; // stretch with no idling on either side
	bit no_idle        = 1'b0; // final stretch, both sides at full rate

	// ------------------------------------------------------------------
	// Predictor: applies one accepted transaction to the shadow registers
	// and returns the result transaction the block must produce for it.
	// ------------------------------------------------------------------
	function automatic bus_result_t apply_transaction(input bus_item_t it);
		bus_result_t r;
		logic [2:0]  op;
		logic        drv;
		logic        wprot;
		int          secn;
		int          cnt;
		int          trk;
		bit          range_bad;
		r    = '0;
		op   = it.instr_byte[2:0];
		drv  = it.instr_byte[4];
		secn = it.sector_field[SEC_W-1:0];
		cnt  = it.sector_count;
		trk  = it.track_addr;
		case (it.opcode)
			OPC_RD_STATUS: r.read_data = {4'b0000, ctl_present, ctl_irq, ctl_ready};
			OPC_RD_KIND: begin
				ctl_irq     = 1'b0;
				r.read_data = BYTE_W'(ctl_kind);
			end
			OPC_RD_RESULT: begin
				if (ctl_kind == KIND_READY) begin
					r.read_data = (ctl_ready[0] ? RES_RDY0 : ERR_NONE) |
					              (ctl_ready[1] ? RES_RDY1 : ERR_NONE);
				end else begin
					// error byte is read once, then the kind falls back to ready status
					r.read_data = ctl_err;
					ctl_kind    = KIND_READY;
				end
			end
			OPC_WR_ADDR_L: ctl_addr = {8'h00, it.bus_data};
			OPC_WR_ADDR_H: begin
				// high byte is ORed in, not loaded
				ctl_addr[15:8] = ctl_addr[15:8] | it.bus_data;
				wprot          = ctl_protect[drv];
				ctl_kind       = KIND_IOERR;
				ctl_err        = ERR_NONE;
				range_bad = trk >= TRACKS || secn == 0 || secn > SECTORS_PER_TRACK ||
				            cnt > SECTORS_PER_TRACK || secn + cnt > SECTORS_PER_TRACK + 1;
				if (!ctl_ready[drv]) begin
					ctl_err = ERR_NRDY;
				end else begin
					case (op) inside
						INS_SEEK: if (trk >= TRACKS) ctl_err = ERR_ADDR;
						INS_FORMAT: begin
							if (trk >= TRACKS) ctl_err = ERR_ADDR;
							else if (wprot) ctl_err = ERR_NRDY; // medium can't open for write
							else begin
								r.xfer_valid  = 1'b1;
								r.xfer_op     = XOP_FORMAT;
								r.xfer_sector = LSEC_W'(trk * SECTORS_PER_TRACK);
								r.xfer_count  = CNT_W'(SECTORS_PER_TRACK);
							end
						end
						INS_READ, INS_VERIFY, INS_WRITE, INS_WR_DEL: begin
							if (range_bad) ctl_err = ERR_ADDR;
							else if (op >= INS_WRITE && wprot) ctl_err = ERR_WPROT;
							else begin
								r.xfer_valid  = 1'b1;
								r.xfer_op     = XOP_READ + XOP_W'(op - INS_READ);
								r.xfer_sector = LSEC_W'(trk * SECTORS_PER_TRACK + secn - 1);
								r.xfer_count  = CNT_W'(cnt);
							end
						end
						default: ; // nop, recalibrate
					endcase
				end
				if (r.xfer_valid) begin
					r.xfer_unit = drv;
					xfers_issued++;
				end
				if (ctl_err != ERR_NONE) cmds_rejected++;
				if (it.chan_word[5:4] == 2'b00) ctl_irq = 1'b1;
			end
			OPC_RESET: begin
				ctl_kind    = KIND_READY;
				ctl_err     = ERR_NONE;
				ctl_irq     = 1'b0;
				ctl_ready   = it.unit_ready;
				ctl_protect = it.unit_protect;
				ctl_present = it.unit_ready != 2'b00;
			end
			OPC_DRV_STAT: begin
				ctl_protect = it.unit_protect;
				// ready change is dropped while an I/O result is unread
				if (ctl_kind != KIND_IOERR && it.unit_ready != ctl_ready) begin
					ctl_ready = it.unit_ready;
					ctl_irq   = 1'b1;
					ready_changes++;
				end
			end
			default: ;
		endcase
		r.irq_pending  = ctl_irq;
		r.iopb_address = ctl_addr;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t: result %0d field %s: got 0x%0h, expected 0x%0h",
			         $realtime, checked, field, got, want);
	endtask

	// ------------------------------------------------------------------
	// Monitor: both sides sampled at the rising edge, before the block's
	// registers update. Input transactions feed the predictor, output
	// transactions are compared against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bus_item_t   seen;
		bus_result_t got;
		bus_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen = {s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24],
				        s_tdata[39:32], s_tdata[47:40], s_tdata[49:48], s_tdata[51:50]};
				expected_results.push_back(apply_transaction(seen));
			end
			if (m_tvalid && m_tready) begin
				got.read_data    = m_tdata[7:0];
				got.irq_pending  = m_tdata[8];
				got.xfer_valid   = m_tuser;
				got.xfer_op      = m_tdata[11:9];
				got.xfer_unit    = m_tdata[12];
				got.xfer_sector  = m_tdata[23:13];
				got.xfer_count   = m_tdata[28:24];
				got.iopb_address = m_tdata[44:29];
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected", int'(m_tdata[44:0]), 0);
				end else begin
					want = expected_results.pop_front();
					if (got.read_data !== want.read_data)
						report_mismatch("read_data", got.read_data, want.read_data);
					if (got.irq_pending !== want.irq_pending)
						report_mismatch("irq_pending", got.irq_pending, want.irq_pending);
					if (got.xfer_valid !== want.xfer_valid)
						report_mismatch("xfer_valid", got.xfer_valid, want.xfer_valid);
					if (got.xfer_op !== want.xfer_op)
						report_mismatch("xfer_op", got.xfer_op, want.xfer_op);
					if (got.xfer_unit !== want.xfer_unit)
						report_mismatch("xfer_unit", got.xfer_unit, want.xfer_unit);
					if (got.xfer_sector !== want.xfer_sector)
						report_mismatch("xfer_sector", got.xfer_sector, want.xfer_sector);
					if (got.xfer_count !== want.xfer_count)
						report_mismatch("xfer_count", got.xfer_count, want.xfer_count);
					if (got.iopb_address !== want.iopb_address)
						report_mismatch("iopb_address", got.iopb_address, want.iopb_address);
					if (m_tdata[47:45] !== 3'b000)
						report_mismatch("padding", m_tdata[47:45], 0);
				end
				checked++;
			end
			// watchdog: any transaction on either side counts as progress
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
					         idle_cycles, expected_results.size());
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result sink: random stall bursts, calm stretches, none at the end.
	// Also decides the calm stretches that the sender follows.
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int mood_left;
		stall_left = 0;
		mood_left  = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mood_left == 0) begin
				calm      = $urandom_range(0, 2) == 0;
				mood_left = $urandom_range(30, 300);
			end else begin
				mood_left--;
			end
			if (no_idle) stall_left = 0;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && !no_idle && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 11);
			end
		end
	end

	// ------------------------------------------------------------------
	// Source side. Called right after a rising edge; returns right after
	// the edge at which the transaction was taken. tvalid is left high so
	// the next call can follow without a bubble.
	// ------------------------------------------------------------------
	task automatic send_transaction(input bus_item_t it);
		if (!no_idle && !calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.opcode;
		s_tdata  <= {4'b0000, it.unit_protect, it.unit_ready, it.sector_field, it.track_addr,
		             it.sector_count, it.instr_byte, it.chan_word, it.bus_data};
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	// item builders
	function automatic bus_item_t plain_item(input logic [OPC_W-1:0] opcode);
		bus_item_t it;
		it        = '0;
		it.opcode = opcode;
		return it;
	endfunction

	function automatic bus_item_t drive_event(input logic [OPC_W-1:0] opcode,
	                                          input logic [1:0] rdy, input logic [1:0] prot);
		bus_item_t it;
		it              = plain_item(opcode);
		it.unit_ready   = rdy;
		it.unit_protect = prot;
		return it;
	endfunction

	function automatic logic [7:0] instr(input logic drv, input logic [2:0] op);
		return {3'b000, drv, 1'b0, op};
	endfunction

	function automatic bus_item_t command(input logic [7:0] ins, input logic [7:0] trk,
	                                      input logic [7:0] secf, input logic [7:0] cnt,
	                                      input logic [7:0] cw, input logic [7:0] addr_hi);
		bus_item_t it;
		it              = plain_item(OPC_WR_ADDR_H);
		it.instr_byte   = ins;
		it.track_addr   = trk;
		it.sector_field = secf;
		it.sector_count = cnt;
		it.chan_word    = cw;
		it.bus_data     = addr_hi;
		return it;
	endfunction

	function automatic bus_item_t random_noise();
		bus_item_t it;
		it.opcode       = OPC_W'($urandom_range(0, 7));
		it.bus_data     = 8'($urandom);
		it.chan_word    = 8'($urandom);
		it.instr_byte   = 8'($urandom);
		it.sector_count = 8'($urandom);
		it.track_addr   = 8'($urandom);
		it.sector_field = 8'($urandom);
		it.unit_ready   = 2'($urandom);
		it.unit_protect = 2'($urandom);
		return it;
	endfunction

	// command mostly inside the legal geometry, so checks get past the range test
	function automatic bus_item_t random_command();
		bus_item_t it;
		int secn;
		it        = random_noise();
		it.opcode = OPC_WR_ADDR_H;
		if ($urandom_range(0, 3) != 0) it.chan_word[5:4] = 2'b00;
		if ($urandom_range(0, 4) != 0) it.track_addr = 8'($urandom_range(0, TRACKS - 1));
		secn = ($urandom_range(0, 4) != 0) ? $urandom_range(1, SECTORS_PER_TRACK)
		                                   : $urandom_range(0, 31);
		it.sector_field[SEC_W-1:0] = SEC_W'(secn);
		if ($urandom_range(0, 4) != 0 && secn >= 1 && secn <= SECTORS_PER_TRACK)
			it.sector_count = 8'($urandom_range(0, SECTORS_PER_TRACK + 1 - secn));
		return it;
	endfunction

	function automatic bus_item_t random_of(input logic [OPC_W-1:0] opcode);
		bus_item_t it;
		it        = random_noise();
		it.opcode = opcode;
		return it;
	endfunction

	// address low, command, then the usual result readout; all but the command are sent at random
	task automatic run_command_sequence();
		if ($urandom_range(0, 2) == 0) send_transaction(random_of(OPC_WR_ADDR_L));
		send_transaction(random_command());
		if ($urandom_range(0, 3) != 0) send_transaction(random_of(OPC_RD_KIND));
		if ($urandom_range(0, 3) != 0) send_transaction(random_of(OPC_RD_RESULT));
		if ($urandom_range(0, 1) == 0) send_transaction(random_of(OPC_RD_STATUS));
	endtask

	task automatic random_reset();
		bus_item_t it;
		it        = random_of(OPC_RESET);
		// mostly at least one drive ready so commands reach the range checks
		if ($urandom_range(0, 7) != 0) it.unit_ready = 2'($urandom_range(1, 3));
		send_transaction(it);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_register_reads();
		bus_item_t it;
		send_transaction(drive_event(OPC_RESET, 2'b01, 2'b10));
		send_transaction(plain_item(OPC_RD_STATUS));
		send_transaction(plain_item(OPC_RD_RESULT));
		it        = '1; // every field at its top, opcode with no effect
		it.opcode = OPC_NONE;
		send_transaction(it);
	endtask

	task automatic test_address_bytes();
		bus_item_t it;
		it          = plain_item(OPC_WR_ADDR_L);
		it.bus_data = 8'hFF;
		send_transaction(it);
		// high byte ORed over the low write; full-track read from sector 1
		send_transaction(command(instr(1'b0, INS_READ), 8'd0, 8'd1, 8'd26, 8'h00, 8'hA5));
		send_transaction(plain_item(OPC_RD_KIND));
		send_transaction(plain_item(OPC_WR_ADDR_L));
	endtask

	task automatic test_command_checks();
		// drive 1 not ready, interrupt masked
		send_transaction(command(instr(1'b1, INS_WRITE), 8'd0, 8'd1, 8'd1, 8'h30, 8'h00));
		send_transaction(plain_item(OPC_RD_RESULT));
		send_transaction(drive_event(OPC_DRV_STAT, 2'b11, 2'b11));
		// format on a protected drive, last track
		send_transaction(command(instr(1'b1, INS_FORMAT), 8'd76, 8'd0, 8'd0, 8'h00, 8'h00));
		// status update with an unread I/O error: only protect bits load
		send_transaction(drive_event(OPC_DRV_STAT, 2'b00, 2'b00));
		send_transaction(command(instr(1'b1, INS_FORMAT), 8'd76, 8'd0, 8'd0, 8'hCF, 8'h80));
		send_transaction(command(instr(1'b0, INS_SEEK), 8'd77, 8'd0, 8'd0, 8'h00, 8'h00));
		send_transaction(command(instr(1'b0, INS_SEEK), 8'd255, 8'd0, 8'd0, 8'h10, 8'h00));
		// highest linear sector; upper sector bits ignored
		send_transaction(command(instr(1'b0, INS_VERIFY), 8'd76, 8'hFA, 8'd1, 8'h20, 8'h00));
		send_transaction(command(instr(1'b0, INS_READ), 8'd10, 8'hE0, 8'd1, 8'h00, 8'h00));
		send_transaction(command(instr(1'b0, INS_READ), 8'd10, 8'd27, 8'd0, 8'h00, 8'h00));
		send_transaction(command(instr(1'b0, INS_WR_DEL), 8'd10, 8'd1, 8'd27, 8'h00, 8'h00));
		// sector plus count runs past the end of the track
		send_transaction(command(instr(1'b0, INS_WRITE), 8'd10, 8'd2, 8'd26, 8'h00, 8'h00));
		send_transaction(drive_event(OPC_RESET, 2'b11, 2'b01));
		send_transaction(command(instr(1'b0, INS_WRITE), 8'd5, 8'd3, 8'd4, 8'h00, 8'h00));
		send_transaction(command(instr(1'b1, INS_NOP), 8'd200, 8'd0, 8'd0, 8'h00, 8'h00));
		send_transaction(command(instr(1'b1, INS_RECAL), 8'd0, 8'd0, 8'd0, 8'h00, 8'h00));
		send_transaction(plain_item(OPC_RD_STATUS));
	endtask

	task automatic test_random_traffic(input int target);
		int pick;
		while (sent_items < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) run_command_sequence();
			else if (pick < 63) random_reset();
			else if (pick < 73) send_transaction(random_of(OPC_DRV_STAT));
			else send_transaction(random_noise());
		end
	endtask

	task automatic test_back_to_back(input int target);
		no_idle = 1'b1;
		random_reset();
		while (sent_items < target) begin
			if ($urandom_range(0, 9) == 0) send_transaction(random_noise());
			else run_command_sequence();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OPC_NONE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reads();
		test_address_bytes();
		test_command_checks();
		test_random_traffic(sent_items + RANDOM_ITEMS);
		test_back_to_back(sent_items + STREAM_ITEMS);

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d bus transactions, %0d results checked, %0d mismatches",
		         sent_items, checked, mismatches);
		$display("Commands: %0d transfer requests issued, %0d rejected; %0d drive ready changes",
		         xfers_issued, cmds_rejected, ready_changes);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
